[sv/mwia_pkg.sv]
// Package for the multi-width integer ALU: command codes, width codes,
// shared constants and the stage-to-stage transaction record.
// No dependencies.
package mwia_pkg;

  localparam int DataW  = 64;
  localparam int CmdW   = 5;
  localparam int WselW  = 2;
  localparam int Stages = DataW;

  localparam logic [CmdW-1:0] CmdAdd  = 5'd0;
  localparam logic [CmdW-1:0] CmdSub  = 5'd1;
  localparam logic [CmdW-1:0] CmdMul  = 5'd2;
  localparam logic [CmdW-1:0] CmdDiv  = 5'd3;
  localparam logic [CmdW-1:0] CmdRem  = 5'd4;
  localparam logic [CmdW-1:0] CmdEq   = 5'd5;
  localparam logic [CmdW-1:0] CmdNe   = 5'd6;
  localparam logic [CmdW-1:0] CmdGt   = 5'd7;
  localparam logic [CmdW-1:0] CmdGe   = 5'd8;
  localparam logic [CmdW-1:0] CmdLt   = 5'd9;
  localparam logic [CmdW-1:0] CmdLe   = 5'd10;
  localparam logic [CmdW-1:0] CmdOr   = 5'd11;
  localparam logic [CmdW-1:0] CmdAnd  = 5'd12;
  localparam logic [CmdW-1:0] CmdXor  = 5'd13;
  localparam logic [CmdW-1:0] CmdShr  = 5'd14;
  localparam logic [CmdW-1:0] CmdShl  = 5'd15;
  localparam logic [CmdW-1:0] CmdLnot = 5'd16;
  localparam logic [CmdW-1:0] CmdBnot = 5'd17;

  localparam logic [WselW-1:0] Wsel8  = 2'd0;
  localparam logic [WselW-1:0] Wsel16 = 2'd1;
  localparam logic [WselW-1:0] Wsel32 = 2'd2;
  localparam logic [WselW-1:0] Wsel64 = 2'd3;

  // One transaction as it moves down the cell chain.
  // For divide: rem is the partial remainder, quo holds shifting
  // dividend bits in its top and quotient bits in its bottom.
  // For multiply: rem is the partial product, quo the multiplier.
  typedef struct packed {
    logic             vld;
    logic [CmdW-1:0]  cmd;
    logic [WselW-1:0] wsel;
    logic             neg_q;
    logic             neg_r;
    logic             dz;
    logic [DataW-1:0] mcand;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] res;
  } mwia_item_t;

  // Sign-extend the low bits of a value at the selected width.
  function automatic logic [DataW-1:0] sext(input logic [DataW-1:0] x,
                                            input logic [WselW-1:0] ws);
    logic [DataW-1:0] r;
    r = x;
    case (ws)
      Wsel8:   r = {{56{x[7]}}, x[7:0]};
      Wsel16:  r = {{48{x[15]}}, x[15:0]};
      Wsel32:  r = {{32{x[31]}}, x[31:0]};
      default: r = x;
    endcase
    return r;
  endfunction

  function automatic logic [DataW-1:0] wmask(input logic [WselW-1:0] ws);
    logic [DataW-1:0] r;
    r = '1;
    case (ws)
      Wsel8:   r = 64'h0000_0000_0000_00ff;
      Wsel16:  r = 64'h0000_0000_0000_ffff;
      Wsel32:  r = 64'h0000_0000_ffff_ffff;
      default: r = '1;
    endcase
    return r;
  endfunction

endpackage

[sv/multi_width_integer_alu.sv]
// Top level of the multi-width integer ALU: front stage, a chain of 64
// cells, final select with sign extension, and the output register.
// Depends on mwia_pkg, mwia_front, mwia_cell.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------
//   input    | in_valid / in_ready    | command, width_sel, operand_a/b
//   output   | out_valid / out_ready  | result, divide_by_zero
//   config   | cfg_we                 | cfg_data (unsigned_compare)
//
// Every command passes the front stage register (loaded at the accepting
// edge), 64 chain cells (one divide or multiply bit each) and the output
// register before out_valid. One transaction enters per cycle while the
// chain is not stalled. The whole chain advances together: when the output
// register holds an untaken result, the chain stalls and in_ready drops.
// Reset clears the valid bits of every stage and the compare flag.
module multi_width_integer_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  command,
  input  logic [1:0]  width_sel,
  input  logic signed [63:0] operand_a,
  input  logic signed [63:0] operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] result,
  output logic        divide_by_zero,
  input  logic        cfg_we,
  input  logic        cfg_data
);

  logic                 ucmp;
  logic                 en;
  mwia_pkg::mwia_item_t chain [mwia_pkg::Stages+1];
  mwia_pkg::mwia_item_t last;
  logic [63:0]          q, rr, fin;

  // chain moves when the output register is free or being emptied
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ucmp <= 1'b0;
    end else if (cfg_we) begin
      ucmp <= cfg_data;
    end
  end

  mwia_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_vld(in_valid),
    .cmd(command), .wsel(width_sel),
    .opa(operand_a), .opb(operand_b), .ucmp(ucmp), .item(chain[0])
  );

  for (genvar i = 0; i < mwia_pkg::Stages; i++) begin : g_cell
    mwia_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .din(chain[i]), .dout(chain[i+1])
    );
  end

  // final select
  always_comb begin
    last = chain[mwia_pkg::Stages];
    q    = last.neg_q ? (64'd0 - last.quo) : last.quo;
    rr   = last.neg_r ? (64'd0 - last.rem) : last.rem;
    case (last.cmd)
      mwia_pkg::CmdMul: fin = last.rem;
      mwia_pkg::CmdDiv: fin = last.dz ? '0 : q;
      mwia_pkg::CmdRem: fin = last.dz ? '0 : rr;
      default:          fin = last.res;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.vld;
    end
    if (en) begin
      result         <= mwia_pkg::sext(fin, last.wsel);
      divide_by_zero <= last.dz;
    end
  end

endmodule

[sv/mwia_front.sv]
// Front stage of the ALU: operand cut to width, the operations done in this stage,
// and setup of divide and multiply for the cell chain.
// Depends on mwia_pkg.
module mwia_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [mwia_pkg::CmdW-1:0]     cmd,
  input  logic [mwia_pkg::WselW-1:0]    wsel,
  input  logic [mwia_pkg::DataW-1:0]    opa,
  input  logic [mwia_pkg::DataW-1:0]    opb,
  input  logic                          ucmp,
  output mwia_pkg::mwia_item_t          item
);

  logic [mwia_pkg::DataW-1:0] a, b, au, bu, ma, mb, m, r;
  logic signed [mwia_pkg::DataW-1:0] sra;
  logic                       lt_ab, lt_ba, na, nb, sh_big;
  logic [6:0]                 wbits;
  logic [5:0]                 sh;
  mwia_pkg::mwia_item_t       nxt;

  always_comb begin
    m     = mwia_pkg::wmask(wsel);
    a     = mwia_pkg::sext(opa, wsel);
    b     = mwia_pkg::sext(opb, wsel);
    au    = a & m;
    bu    = b & m;
    na    = a[63];
    nb    = b[63];
    ma    = na ? (64'd0 - a) : a;
    mb    = nb ? (64'd0 - b) : b;
    lt_ab = ucmp ? (au < bu) : ($signed(a) < $signed(b));
    lt_ba = ucmp ? (bu < au) : ($signed(b) < $signed(a));
    wbits = 7'd8 << wsel;
    sh_big = (bu >= {57'd0, wbits});
    sh    = bu[5:0];
    // arithmetic shift kept in its own signed variable
    sra   = $signed(a) >>> sh;
    r     = '0;
    case (cmd)
      mwia_pkg::CmdAdd:  r = a + b;
      mwia_pkg::CmdSub:  r = a - b;
      mwia_pkg::CmdEq:   r = {63'd0, au == bu};
      mwia_pkg::CmdNe:   r = {63'd0, au != bu};
      mwia_pkg::CmdGt:   r = {63'd0, lt_ba};
      mwia_pkg::CmdGe:   r = {63'd0, !lt_ab};
      mwia_pkg::CmdLt:   r = {63'd0, lt_ab};
      mwia_pkg::CmdLe:   r = {63'd0, !lt_ba};
      mwia_pkg::CmdOr:   r = a | b;
      mwia_pkg::CmdAnd:  r = a & b;
      mwia_pkg::CmdXor:  r = a ^ b;
      mwia_pkg::CmdShr:  r = sh_big ? {64{na}} : sra;
      mwia_pkg::CmdShl:  r = sh_big ? '0 : (a << sh);
      mwia_pkg::CmdLnot: r = {63'd0, au == '0};
      mwia_pkg::CmdBnot: r = ~a;
      default:           r = '0;
    endcase

    nxt       = '0;
    nxt.vld   = in_vld;
    nxt.cmd   = cmd;
    nxt.wsel  = wsel;
    nxt.res   = r;
    nxt.dz    = ((cmd == mwia_pkg::CmdDiv) || (cmd == mwia_pkg::CmdRem)) && (bu == '0);
    nxt.neg_q = na ^ nb;
    nxt.neg_r = na;
    if (cmd == mwia_pkg::CmdMul) begin
      nxt.mcand = a;
      nxt.quo   = b;
    end else begin
      nxt.mcand = mb;
      nxt.quo   = ma;
    end
  end

  // Stage register; valid bit cleared on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      item.vld <= 1'b0;
    end else if (en) begin
      item.vld <= nxt.vld;
    end
    if (en) begin
      {item.cmd, item.wsel, item.neg_q, item.neg_r, item.dz,
       item.mcand, item.rem, item.quo, item.res} <=
      {nxt.cmd, nxt.wsel, nxt.neg_q, nxt.neg_r, nxt.dz,
       nxt.mcand, nxt.rem, nxt.quo, nxt.res};
    end
  end

endmodule

[sv/mwia_cell.sv]
// One cell of the chain: one restoring-divide step or one shift-add
// multiply step per transaction, then a register to the next cell.
// Depends on mwia_pkg.
module mwia_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  mwia_pkg::mwia_item_t din,
  output mwia_pkg::mwia_item_t dout
);

  mwia_pkg::mwia_item_t nxt;
  logic [mwia_pkg::DataW:0] trial;
  logic [mwia_pkg::DataW-1:0] rsh;

  always_comb begin
    nxt   = din;
    rsh   = {din.rem[62:0], din.quo[63]};
    trial = {din.rem[63], rsh} - {1'b0, din.mcand};
    if (din.cmd == mwia_pkg::CmdMul) begin
      // partial product accumulates from the multiplier's low bit up
      nxt.rem = din.rem + (din.quo[0] ? din.mcand : '0);
      nxt.quo = {1'b0, din.quo[63:1]};
      nxt.mcand = {din.mcand[62:0], 1'b0};
    end else begin
      // restoring division step
      if (!trial[64]) begin
        nxt.rem = trial[63:0];
        nxt.quo = {din.quo[62:0], 1'b1};
      end else begin
        nxt.rem = rsh;
        nxt.quo = {din.quo[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      {dout.cmd, dout.wsel, dout.neg_q, dout.neg_r, dout.dz,
       dout.mcand, dout.rem, dout.quo, dout.res} <=
      {nxt.cmd, nxt.wsel, nxt.neg_q, nxt.neg_r, nxt.dz,
       nxt.mcand, nxt.rem, nxt.quo, nxt.res};
    end
  end

endmodule

[sv/mwia_checker.sv]
// Port-level checker for the multi-width integer ALU, bound to the top.
// Depends on multi_width_integer_alu ports only.
module mwia_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] result,
  input logic        divide_by_zero
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result))
    else $error("result changed while stalled");

  // a zero divisor always forces a zero result
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result == 64'd0)
    else $error("divide by zero with nonzero result");

  // input is taken whenever the output side is free
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind multi_width_integer_alu mwia_checker u_mwia_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .result(result),
  .divide_by_zero(divide_by_zero)
);

[sim/multi_width_integer_alu_test.sv]
// Testbench for the multi-width integer ALU: directed table, then random ops
// checked against a behavioral predictor. Depends on mwia_pkg and the DUT.
`timescale 1ns / 100ps
module multi_width_integer_alu_test;

  typedef struct {
    logic [mwia_pkg::CmdW-1:0]  cmd;
    logic [mwia_pkg::WselW-1:0] ws;
    logic [63:0]      a;
    logic [63:0]      b;
    logic             known;
    logic [63:0]      res;
    logic             dz;
  } op_row_t;

  typedef struct {
    logic [63:0] res;
    logic        dz;
  } alu_out_t;

  localparam int Latency = 66;
  localparam int CycleLimit = 400000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_we = 0, cfg_data = 0;
  logic in_ready, out_valid, divide_by_zero;
  logic [4:0] command = 0;
  logic [1:0] width_sel = 0;
  logic signed [63:0] operand_a = 0, operand_b = 0, result;

  logic ucmp = 0;
  alu_out_t pending_q[$];
  int errors = 0, sent = 0, checked = 0, cycles = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 0;

  multi_width_integer_alu DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .width_sel(width_sel), .operand_a(operand_a),
    .operand_b(operand_b), .out_valid(out_valid), .out_ready(out_ready),
    .result(result), .divide_by_zero(divide_by_zero),
    .cfg_we(cfg_we), .cfg_data(cfg_data));

  initial begin
    forever #1 clk = ~clk;
  end

  // Sign-extend at width code
  function automatic logic [63:0] fit(logic [63:0] x, logic [1:0] ws);
    case (ws)
      mwia_pkg::Wsel8:  return {{56{x[7]}}, x[7:0]};
      mwia_pkg::Wsel16: return {{48{x[15]}}, x[15:0]};
      mwia_pkg::Wsel32: return {{32{x[31]}}, x[31:0]};
      default:          return x;
    endcase
  endfunction

  // Predict one ALU transaction
  function automatic alu_out_t alu_predict(logic [mwia_pkg::CmdW-1:0] cmd,
                                           logic [1:0] ws,
                                           logic [63:0] ai, logic [63:0] bi);
    alu_out_t o;
    int unsigned w;
    logic [63:0] m, a, b, au, bu, r, ma, mb;
    logic lt_ab, lt_ba, na, nb;
    w = 8 << ws;
    m = (w == 64) ? '1 : ((64'd1 << w) - 1);
    a = fit(ai, ws);
    b = fit(bi, ws);
    au = a & m;
    bu = b & m;
    r = 0;
    o.dz = 0;
    if (ucmp) begin
      lt_ab = au < bu;
      lt_ba = bu < au;
    end else begin
      lt_ab = $signed(a) < $signed(b);
      lt_ba = $signed(b) < $signed(a);
    end
    na = a[63];
    nb = b[63];
    ma = na ? -a : a;
    mb = nb ? -b : b;
    case (cmd)
      mwia_pkg::CmdAdd: r = a + b;
      mwia_pkg::CmdSub: r = a - b;
      mwia_pkg::CmdMul: r = a * b;
      mwia_pkg::CmdDiv, mwia_pkg::CmdRem: begin
        if (bu == 0) o.dz = 1;
        else if (cmd == mwia_pkg::CmdDiv) r = (na != nb) ? -(ma / mb) : ma / mb;
        else r = na ? -(ma % mb) : ma % mb;
      end
      mwia_pkg::CmdEq: r = {63'd0, au == bu};
      mwia_pkg::CmdNe: r = {63'd0, au != bu};
      mwia_pkg::CmdGt: r = {63'd0, lt_ba};
      mwia_pkg::CmdGe: r = {63'd0, !lt_ab};
      mwia_pkg::CmdLt: r = {63'd0, lt_ab};
      mwia_pkg::CmdLe: r = {63'd0, !lt_ba};
      mwia_pkg::CmdOr: r = a | b;
      mwia_pkg::CmdAnd: r = a & b;
      mwia_pkg::CmdXor: r = a ^ b;
      mwia_pkg::CmdShr:
        r = (bu >= w) ? {64{a[63]}} : $unsigned($signed(a) >>> bu[5:0]);
      mwia_pkg::CmdShl: r = (bu >= w) ? 64'd0 : a << bu[5:0];
      mwia_pkg::CmdLnot: r = {63'd0, au == 0};
      mwia_pkg::CmdBnot: r = ~a;
      default: r = 0;
    endcase
    o.res = fit(r, ws);
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = '1;
      2: v = {1'b1, 63'd0};
      3: v = {1'b0, {63{1'b1}}};
      4: v = 64'($urandom_range(0, 70));
      5: v = {{32{v[7]}}, 24'd0, v[7:0]};
      default: ;
    endcase
    return v;
  endfunction

  // Directed stimulus; known=1 rows carry a typed-in result
  op_row_t dir_tab[] = '{
    '{mwia_pkg::CmdAdd, mwia_pkg::Wsel8, 64'h7f, 64'h1, 1, 64'hffff_ffff_ffff_ff80, 0},
    '{mwia_pkg::CmdSub, mwia_pkg::Wsel16, 64'h8000, 64'h1, 1, 64'h7fff, 0},
    '{mwia_pkg::CmdMul, mwia_pkg::Wsel64, '1, '1, 1, 64'd1, 0},
    '{mwia_pkg::CmdDiv, mwia_pkg::Wsel32, 64'd5, 64'd0, 1, 64'd0, 1},
    '{mwia_pkg::CmdRem, mwia_pkg::Wsel8, 64'd7, 64'h100, 1, 64'd0, 1},
    '{mwia_pkg::CmdDiv, mwia_pkg::Wsel64, {1'b1, 63'd0}, '1, 1, {1'b1, 63'd0}, 0},
    '{mwia_pkg::CmdRem, mwia_pkg::Wsel64, {1'b1, 63'd0}, '1, 1, 64'd0, 0},
    '{mwia_pkg::CmdDiv, mwia_pkg::Wsel8, 64'h80, 64'hff, 1, 64'hffff_ffff_ffff_ff80, 0},
    '{mwia_pkg::CmdDiv, mwia_pkg::Wsel16, -64'sd7, 64'd2, 0, 0, 0},
    '{mwia_pkg::CmdRem, mwia_pkg::Wsel32, -64'sd7, 64'd2, 0, 0, 0},
    '{mwia_pkg::CmdEq, mwia_pkg::Wsel8, 64'h1ff, 64'hff, 1, 64'd1, 0},
    '{mwia_pkg::CmdNe, mwia_pkg::Wsel64, 64'd3, 64'd3, 1, 64'd0, 0},
    '{mwia_pkg::CmdGt, mwia_pkg::Wsel64, '1, 64'd1, 0, 0, 0},
    '{mwia_pkg::CmdGe, mwia_pkg::Wsel32, 64'h8000_0000, 64'd0, 0, 0, 0},
    '{mwia_pkg::CmdLt, mwia_pkg::Wsel16, 64'hffff, 64'd0, 0, 0, 0},
    '{mwia_pkg::CmdLe, mwia_pkg::Wsel8, 64'd5, 64'd5, 1, 64'd1, 0},
    '{mwia_pkg::CmdOr, mwia_pkg::Wsel64, 64'hf0f0, 64'h0f0f, 1, 64'hffff, 0},
    '{mwia_pkg::CmdAnd, mwia_pkg::Wsel32, '1, 64'h1234_5678, 1, 64'h1234_5678, 0},
    '{mwia_pkg::CmdXor, mwia_pkg::Wsel8, 64'h0f, 64'hff, 1, 64'hffff_ffff_ffff_fff0, 0},
    '{mwia_pkg::CmdShr, mwia_pkg::Wsel8, 64'h80, 64'd8, 1, '1, 0},
    '{mwia_pkg::CmdShr, mwia_pkg::Wsel64, {1'b1, 63'd0}, 64'd63, 1, '1, 0},
    '{mwia_pkg::CmdShl, mwia_pkg::Wsel16, 64'd1, 64'd15, 1, 64'hffff_ffff_ffff_8000, 0},
    '{mwia_pkg::CmdShl, mwia_pkg::Wsel32, 64'd1, '1, 1, 64'd0, 0},
    '{mwia_pkg::CmdLnot, mwia_pkg::Wsel8, 64'h100, 64'd9, 1, 64'd1, 0},
    '{mwia_pkg::CmdBnot, mwia_pkg::Wsel64, 64'd0, 64'd0, 1, '1, 0},
    '{5'd31, mwia_pkg::Wsel64, '1, '1, 1, 64'd0, 0}
  };

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= !hold_recv && ($urandom_range(0, 99) >= recv_idle);
  end

  // Result checker
  always @(posedge clk) begin
    alu_out_t e;
    if (!rst && out_valid && out_ready) begin
      checked <= checked + 1;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transaction result=%h", $time, result);
        errors <= errors + 1;
      end else begin
        e = pending_q.pop_front();
        if (result !== e.res) begin
          $display("%0t: result expected %h actual %h", $time, e.res, result);
          errors <= errors + 1;
        end
        if (divide_by_zero !== e.dz) begin
          $display("%0t: divide_by_zero expected %b actual %b",
                   $time, e.dz, divide_by_zero);
          errors <= errors + 1;
        end
      end
    end
  end

  // Offer one transaction, wait for acceptance; valid stays up afterwards
  task automatic send_op(op_row_t row);
    alu_out_t e;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    command <= row.cmd;
    width_sel <= row.ws;
    operand_a <= row.a;
    operand_b <= row.b;
    e = alu_predict(row.cmd, row.ws, row.a, row.b);
    if (row.known) begin
      e.res = row.res;
      e.dz = row.dz;
    end
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(e);
    sent++;
  endtask

  // Drop valid after the last transaction of a group
  task automatic stop_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain_and_set(logic flag);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= flag;
    @(posedge clk);
    cfg_we <= 0;
    ucmp = flag;
  endtask

  task automatic random_ops(int n);
    op_row_t row;
    for (int i = 0; i < n; i++) begin
      row.cmd = ($urandom_range(0, 40) == 0) ? 5'($urandom_range(18, 31))
                                             : 5'($urandom_range(0, 17));
      row.ws = 2'($urandom_range(0, 3));
      row.a = rand64();
      row.b = rand64();
      row.known = 0;
      row.res = 0;
      row.dz = 0;
      send_op(row);
    end
    stop_input();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir_tab[i]) send_op(dir_tab[i]);
    stop_input();
    drain_and_set(1);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cmd >= mwia_pkg::CmdGt && dir_tab[i].cmd <= mwia_pkg::CmdLe)
        send_op(dir_tab[i]);
    end
    stop_input();
    send_idle = 29;
    recv_idle = 73;
    random_ops(300);
    drain_and_set(0);
    // Long receiver hold-off while sender keeps pushing
    send_idle = 0;
    recv_idle = 0;
    hold_recv = 1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_recv = 0;
      end
      random_ops(150);
    join
    send_idle = 73;
    recv_idle = 29;
    random_ops(300);
    drain_and_set(1);
    random_ops(250);
    drain_and_set(0);
    send_idle = 0;
    recv_idle = 0;
    random_ops(350);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    $display("Sent %0d ALU transactions, %0d results checked, over all", sent, checked);
    $display("commands, widths and both compare modes, with stalls on both sides.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
